### rtl/battery_discharge_monitor_top_macros.svh
// assertion macros shared by the monitor checker
// no dependencies; include once per file that asserts
`ifndef BATTERY_DISCHARGE_MONITOR_TOP_MACROS_SVH
`define BATTERY_DISCHARGE_MONITOR_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define BDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define BDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bdm_pkg.sv
// shared widths, codes and controller/datapath interface types of the monitor
// no dependencies
package bdm_pkg;

  localparam int VOLT_W     = 18;
  localparam int CURR_W     = 16;
  localparam int TIME_W     = 16;
  localparam int CNT_W      = 32;
  localparam int CONF_W     = 8;
  localparam int IDLE_W     = 16;
  localparam int THR_C_W    = CURR_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // accumulator width, 40 to 64; output fields stay 64 bits
  localparam int ACC_WIDTH  = 64;
  localparam int OUT_ACC_W  = 64;

  localparam int ISUM_W  = CURR_W + 1;
  localparam int VSUM_W  = VOLT_W + 1;
  localparam int QTERM_W = ISUM_W + TIME_W;
  localparam int IV_W    = ISUM_W + VSUM_W;
  localparam int ETERM_W = IV_W + TIME_W;
  localparam int SUM_W   = ((ACC_WIDTH > ETERM_W) ? ACC_WIDTH : ETERM_W) + 1;

  localparam int IN_BITS     = VOLT_W + CURR_W + TIME_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = CNT_W + 2 + 1 + 1 + 2 * OUT_ACC_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  localparam logic [VOLT_W-1:0]  LOW_VOLT_RST  = 18'd100;
  localparam logic [VOLT_W-1:0]  HALF_VOLT_RST = 18'd0;
  localparam logic [THR_C_W-1:0] LOW_CURR_RST  = 17'h1FFFF;
  localparam logic [THR_C_W-1:0] HIGH_CURR_RST = 17'h1FFFF;
  localparam logic [CONF_W-1:0]  CONFIRM_RST   = 8'd3;
  localparam logic [IDLE_W-1:0]  IDLE_RST      = 16'd3;

  typedef enum logic [1:0] {
    STOP_RUNNING   = 2'd0,
    STOP_LOW_VOLT  = 2'd1,
    STOP_LOW_CURR  = 2'd2,
    STOP_HIGH_CURR = 2'd3
  } stop_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_VOLT  = 3'd0,
    CFG_HALF_VOLT = 3'd1,
    CFG_LOW_CURR  = 3'd2,
    CFG_HIGH_CURR = 3'd3,
    CFG_CONFIRM   = 3'd4,
    CFG_IDLE      = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [VOLT_W-1:0]  low_volt;
    logic [VOLT_W-1:0]  half_volt;
    logic [THR_C_W-1:0] low_curr;
    logic [THR_C_W-1:0] high_curr;
    logic [CONF_W-1:0]  confirm;
    logic [IDLE_W-1:0]  idle;
    logic               confirm_reload;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic integrate;
  } status_t;

endpackage

### rtl/battery_discharge_monitor_top.sv
// each input beat runs step, then mul and acc when the sample is integrated, then done
// one item at a time; the shared multiply chain (sums, i*v, *dt)
// and the two saturating adds run one after the other in the datapath
// the next input beat is taken while a result beat still waits in the output register
// reset: synchronous, active high; config registers and run state go to their
// power-up values, no clearing pass
module battery_discharge_monitor_top (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // voltage_mv[17:0], current_ma[33:18], elapsed_ms[49:34], zero pad [55:50]
  input  logic [bdm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // sample_number[31:0], stop_reason[33:32], load_enable[34], half_load_cmd[35],
  // charge_total[99:36], energy_total[163:100], zero pad [167:164]
  output logic [bdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // config write port, no read-back
  input  logic                            cfg_we,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bdm_pkg::cfg_t    cfg;
  bdm_pkg::cmd_t    cmd;
  bdm_pkg::status_t status;

  // threshold, confirm and idle registers; confirm write restarts both counters
  bdm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle -> step -> (mul -> acc when integrating) -> done
  // done parks until the output register is free
  bdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // step stage decides stops, half-load and load enable, and forms the sums;
  // mul and acc stages finish the energy product and update the accumulators
  bdm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (s_axis_tdata),
    .status   (status),
    .out_data (m_axis_tdata)
  );

endmodule

### rtl/bdm_cfg.sv
// configuration register file of the monitor
// depends on bdm_pkg
module bdm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdm_pkg::CFG_DATA_W-1:0] cfg_data,
  output bdm_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_volt       <= bdm_pkg::LOW_VOLT_RST;
      cfg.half_volt      <= bdm_pkg::HALF_VOLT_RST;
      cfg.low_curr       <= bdm_pkg::LOW_CURR_RST;
      cfg.high_curr      <= bdm_pkg::HIGH_CURR_RST;
      cfg.confirm        <= bdm_pkg::CONFIRM_RST;
      cfg.idle           <= bdm_pkg::IDLE_RST;
      cfg.confirm_reload <= 1'b0;
    end else begin
      cfg.confirm_reload <= 1'b0;
      if (cfg_we) begin
        unique case (bdm_pkg::cfg_idx_t'(cfg_index))
          bdm_pkg::CFG_LOW_VOLT:  cfg.low_volt  <= cfg_data[bdm_pkg::VOLT_W-1:0];
          bdm_pkg::CFG_HALF_VOLT: cfg.half_volt <= cfg_data[bdm_pkg::VOLT_W-1:0];
          bdm_pkg::CFG_LOW_CURR:  cfg.low_curr  <= cfg_data[bdm_pkg::THR_C_W-1:0];
          bdm_pkg::CFG_HIGH_CURR: cfg.high_curr <= cfg_data[bdm_pkg::THR_C_W-1:0];
          bdm_pkg::CFG_CONFIRM: begin
            cfg.confirm        <= cfg_data[bdm_pkg::CONF_W-1:0];
            // both confirm counters restart from the new count
            cfg.confirm_reload <= 1'b1;
          end
          bdm_pkg::CFG_IDLE:      cfg.idle      <= cfg_data[bdm_pkg::IDLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/bdm_ctrl.sv
// sequencing state machine of the monitor: handshakes and datapath commands
// depends on bdm_pkg
module bdm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bdm_pkg::status_t status,
  output bdm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  state_t state;

  always_comb begin
    cmd      = '0;
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.load     = in_valid;
      ST_STEP: cmd.step     = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_ACC:  cmd.acc      = 1'b1;
      ST_DONE: cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) state <= ST_STEP;
        ST_STEP: state <= status.integrate ? ST_MUL : ST_DONE;
        ST_MUL:  state <= ST_ACC;
        ST_ACC:  state <= ST_DONE;
        ST_DONE: if (cmd.out_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/bdm_dp.sv
// datapath of the monitor: thresholds, confirm counters, products, accumulators
// depends on bdm_pkg
module bdm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bdm_pkg::cfg_t                   cfg,
  input  bdm_pkg::cmd_t                   cmd,
  input  logic [bdm_pkg::IN_TDATA_W-1:0]  in_data,
  output bdm_pkg::status_t                status,
  output logic [bdm_pkg::OUT_TDATA_W-1:0] out_data
);

  typedef struct packed {
    logic [bdm_pkg::CONF_W-1:0] left;
    logic                       stop;
  } conf_res_t;

  function automatic conf_res_t conf_step(input logic [bdm_pkg::CONF_W-1:0] left,
                                          input logic                       hit,
                                          input logic [bdm_pkg::CONF_W-1:0] limit);
    conf_res_t r;
    r.left = left;
    r.stop = 1'b0;
    if (hit) begin
      // a count of zero behaves like one
      if (left <= (bdm_pkg::CONF_W)'(1)) begin
        r.left = '0;
        r.stop = 1'b1;
      end else begin
        r.left = left - (bdm_pkg::CONF_W)'(1);
      end
    end else if (left < limit) begin
      r.left = left + (bdm_pkg::CONF_W)'(1);
    end
    return r;
  endfunction

  function automatic logic [bdm_pkg::ACC_WIDTH-1:0] sat_add(
      input logic [bdm_pkg::ACC_WIDTH-1:0] acc,
      input logic [bdm_pkg::ETERM_W-1:0]   term);
    logic [bdm_pkg::SUM_W-1:0] sum;
    sum = (bdm_pkg::SUM_W)'(acc) + (bdm_pkg::SUM_W)'(term);
    if (sum[bdm_pkg::SUM_W-1:bdm_pkg::ACC_WIDTH] != '0) begin
      return '1;
    end
    return sum[bdm_pkg::ACC_WIDTH-1:0];
  endfunction

  // latched item
  logic [bdm_pkg::VOLT_W-1:0] v_in;
  logic [bdm_pkg::CURR_W-1:0] i_in;
  logic [bdm_pkg::TIME_W-1:0] dt_in;

  // run state
  logic [bdm_pkg::CNT_W-1:0]     sample_counter;
  logic [bdm_pkg::CONF_W-1:0]    volt_left;
  logic [bdm_pkg::CONF_W-1:0]    curr_left;
  logic [bdm_pkg::VOLT_W-1:0]    prev_v;
  logic [bdm_pkg::CURR_W-1:0]    prev_i;
  logic [bdm_pkg::ACC_WIDTH-1:0] charge_acc;
  logic [bdm_pkg::ACC_WIDTH-1:0] energy_acc;
  logic                          half_armed;
  bdm_pkg::stop_t                stop_code;
  logic                          load_en;
  logic                          half_cmd;

  // products
  logic [bdm_pkg::QTERM_W-1:0] q_term;
  logic [bdm_pkg::IV_W-1:0]    iv;
  logic [bdm_pkg::ETERM_W-1:0] e_term;

  // step decisions
  logic                       running;
  logic [bdm_pkg::CNT_W-1:0]  cnt_next;
  logic [bdm_pkg::ISUM_W-1:0] isum;
  logic [bdm_pkg::VSUM_W-1:0] vsum;
  logic                       hit_high;
  logic                       half_hit;
  conf_res_t                  vres;
  conf_res_t                  cres;
  bdm_pkg::stop_t             stop_next;
  logic [bdm_pkg::CONF_W-1:0] volt_left_next;
  logic [bdm_pkg::CONF_W-1:0] curr_left_next;
  logic                       armed_next;
  logic                       half_next;
  logic                       load_next;

  always_comb begin
    running  = (stop_code == bdm_pkg::STOP_RUNNING);
    cnt_next = (&sample_counter) ? sample_counter
                                 : sample_counter + (bdm_pkg::CNT_W)'(1);
    isum     = (bdm_pkg::ISUM_W)'(i_in) + (bdm_pkg::ISUM_W)'(prev_i);
    vsum     = (bdm_pkg::VSUM_W)'(v_in) + (bdm_pkg::VSUM_W)'(prev_v);
    status.integrate = running &&
        ((cnt_next - (bdm_pkg::CNT_W)'(1)) > (bdm_pkg::CNT_W)'(cfg.idle));

    hit_high = !cfg.high_curr[bdm_pkg::THR_C_W-1] &&
               (i_in >= cfg.high_curr[bdm_pkg::CURR_W-1:0]);
    half_hit = (cfg.half_volt != '0) && half_armed && (v_in <= cfg.half_volt);
    vres     = conf_step(volt_left, v_in <= cfg.low_volt, cfg.confirm);
    cres     = conf_step(curr_left, i_in <= cfg.low_curr[bdm_pkg::CURR_W-1:0],
                         cfg.confirm);

    stop_next      = stop_code;
    volt_left_next = volt_left;
    curr_left_next = curr_left;
    armed_next     = half_armed;
    half_next      = 1'b0;
    load_next      = 1'b0;
    if (running) begin
      stop_next = hit_high ? bdm_pkg::STOP_HIGH_CURR : bdm_pkg::STOP_RUNNING;
      if (!hit_high) begin
        // half-load sample skips the low-voltage count
        if (half_hit) begin
          half_next  = 1'b1;
          armed_next = 1'b0;
        end else begin
          volt_left_next = vres.left;
          if (vres.stop) stop_next = bdm_pkg::STOP_LOW_VOLT;
        end
      end
      if ((stop_next == bdm_pkg::STOP_RUNNING) &&
          (cnt_next > (bdm_pkg::CNT_W)'(cfg.idle)) &&
          !cfg.low_curr[bdm_pkg::THR_C_W-1]) begin
        curr_left_next = cres.left;
        if (cres.stop) stop_next = bdm_pkg::STOP_LOW_CURR;
      end
      load_next = (stop_next == bdm_pkg::STOP_RUNNING) &&
                  (cnt_next >= (bdm_pkg::CNT_W)'(cfg.idle));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      volt_left      <= bdm_pkg::CONFIRM_RST;
      curr_left      <= bdm_pkg::CONFIRM_RST;
      prev_v         <= '0;
      prev_i         <= '0;
      charge_acc     <= '0;
      energy_acc     <= '0;
      half_armed     <= 1'b1;
      stop_code      <= bdm_pkg::STOP_RUNNING;
      load_en        <= 1'b0;
      half_cmd       <= 1'b0;
    end else begin
      if (cfg.confirm_reload) begin
        volt_left <= cfg.confirm;
        curr_left <= cfg.confirm;
      end
      if (cmd.step) begin
        load_en  <= load_next;
        half_cmd <= half_next;
        if (running) begin
          sample_counter <= cnt_next;
          prev_v         <= v_in;
          prev_i         <= i_in;
          volt_left      <= volt_left_next;
          curr_left      <= curr_left_next;
          half_armed     <= armed_next;
          stop_code      <= stop_next;
        end
      end
      if (cmd.mul) begin
        charge_acc <= sat_add(charge_acc, (bdm_pkg::ETERM_W)'(q_term));
      end
      if (cmd.acc) begin
        energy_acc <= sat_add(energy_acc, e_term);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_in  <= in_data[bdm_pkg::VOLT_W-1:0];
      i_in  <= in_data[bdm_pkg::VOLT_W +: bdm_pkg::CURR_W];
      dt_in <= in_data[bdm_pkg::VOLT_W + bdm_pkg::CURR_W +: bdm_pkg::TIME_W];
    end
    if (cmd.step) begin
      q_term <= (bdm_pkg::QTERM_W)'(isum) * (bdm_pkg::QTERM_W)'(dt_in);
      iv     <= (bdm_pkg::IV_W)'(isum) * (bdm_pkg::IV_W)'(vsum);
    end
    if (cmd.mul) begin
      e_term <= (bdm_pkg::ETERM_W)'(iv) * (bdm_pkg::ETERM_W)'(dt_in);
    end
    if (cmd.out_load) begin
      out_data <= {{(bdm_pkg::OUT_PAD_W){1'b0}},
                   (bdm_pkg::OUT_ACC_W)'(energy_acc),
                   (bdm_pkg::OUT_ACC_W)'(charge_acc),
                   half_cmd, load_en, stop_code, sample_counter};
    end
  end

endmodule

### rtl/bdm_checker.sv
// port-level checks of the monitor, bound to the top level
// depends on bdm_pkg and battery_discharge_monitor_top_macros.svh
`include "battery_discharge_monitor_top_macros.svh"

module bdm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result beat holds
  `BDM_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // one item at a time: no input beat right after one is taken
  `BDM_ASSERT_NEXT(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")

  // a stopped run keeps the load off; the half-load command may share the stopping sample
  `BDM_ASSERT_NOW(a_stop_quiet, clk, rst, m_axis_tvalid && (m_axis_tdata[33:32] != bdm_pkg::STOP_RUNNING), !m_axis_tdata[34], "load enabled after stop")

  // every result follows at least one counted sample
  `BDM_ASSERT_NOW(a_count_nonzero, clk, rst, m_axis_tvalid, m_axis_tdata[31:0] != 32'd0, "result with zero sample count")

endmodule

bind battery_discharge_monitor_top bdm_checker u_bdm_checker (.*);

### tb/tb_battery_discharge_monitor_top.sv
// self-checking bench for the battery discharge monitor: directed and random sample beats
// against a cycle-free predictor held in a scoreboard class
// depends on bdm_pkg and battery_discharge_monitor_top
`timescale 1ns / 1ps

module tb_battery_discharge_monitor_top;
  import bdm_pkg::*;

  localparam int VOLT_MAX    = (1 << VOLT_W) - 1;
  localparam int CURR_MAX    = (1 << CURR_W) - 1;
  localparam int TIME_MAX    = (1 << TIME_W) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam logic [63:0] ACC_MAX = {64{1'b1}} >> (64 - ACC_WIDTH);

  // indexes past the register map, writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

  typedef struct {
    logic [VOLT_W-1:0] voltage_mv;
    logic [CURR_W-1:0] current_ma;
    logic [TIME_W-1:0] elapsed_ms;
  } sample_t;

  typedef struct {
    logic [CNT_W-1:0]     sample_number;
    stop_t                stop_reason;
    logic                 load_enable;
    logic                 half_load_cmd;
    logic [OUT_ACC_W-1:0] charge_total;
    logic [OUT_ACC_W-1:0] energy_total;
  } monitor_result_t;

  // predictor of the monitor plus the queue of results still owed by the block
  class discharge_scoreboard;
    logic [VOLT_W-1:0]         low_volt, half_volt;
    logic signed [THR_C_W-1:0] low_curr, high_curr;
    logic [CONF_W-1:0]         confirm;
    logic [IDLE_W-1:0]         idle;

    logic [CNT_W-1:0]  count;
    logic [CONF_W-1:0] volt_left, curr_left;
    logic [VOLT_W-1:0] prev_v;
    logic [CURR_W-1:0] prev_i;
    logic [63:0]       charge, energy;
    bit                half_armed;
    stop_t             run_stop;

    monitor_result_t expected_q[$];
    int              mismatches;

    function new();
      low_volt   = LOW_VOLT_RST;
      half_volt  = HALF_VOLT_RST;
      low_curr   = LOW_CURR_RST;
      high_curr  = HIGH_CURR_RST;
      confirm    = CONFIRM_RST;
      idle       = IDLE_RST;
      count      = '0;
      volt_left  = CONFIRM_RST;
      curr_left  = CONFIRM_RST;
      prev_v     = '0;
      prev_i     = '0;
      charge     = '0;
      energy     = '0;
      half_armed = 1'b1;
      run_stop   = STOP_RUNNING;
      mismatches = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LOW_VOLT:  low_volt  = data[VOLT_W-1:0];
        CFG_HALF_VOLT: half_volt = data[VOLT_W-1:0];
        CFG_LOW_CURR:  low_curr  = data[THR_C_W-1:0];
        CFG_HIGH_CURR: high_curr = data[THR_C_W-1:0];
        CFG_CONFIRM: begin
          // a new confirm count reloads both up/down counters
          confirm   = data[CONF_W-1:0];
          volt_left = data[CONF_W-1:0];
          curr_left = data[CONF_W-1:0];
        end
        CFG_IDLE:      idle = data[IDLE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] sat_add(logic [63:0] acc, logic [63:0] term);
      if (acc > ACC_MAX || term > ACC_MAX - acc) return ACC_MAX;
      return acc + term;
    endfunction

    // one up/down step, returns 1 when the stop is confirmed
    function bit confirm_step(input logic [CONF_W-1:0] left, input bit hit,
                              output logic [CONF_W-1:0] left_next);
      left_next = left;
      if (hit) begin
        if (left <= 1) begin
          left_next = '0;
          return 1'b1;
        end
        left_next = left - 1'b1;
      end else if (left < confirm) begin
        left_next = left + 1'b1;
      end
      return 1'b0;
    endfunction

    // works out the result of one sample, commits the new state only when asked
    function monitor_result_t advance(sample_t s, bit commit);
      monitor_result_t   r;
      logic [CNT_W-1:0]  n;
      logic [CONF_W-1:0] vl, cl, nxt;
      logic [VOLT_W-1:0] pv;
      logic [CURR_W-1:0] pi;
      logic [63:0]       c, e, isum, vsum, dt;
      bit                armed;
      stop_t             st;
      logic signed [THR_C_W-1:0] cur;

      n = count; vl = volt_left; cl = curr_left; pv = prev_v; pi = prev_i;
      c = charge; e = energy; armed = half_armed; st = run_stop;
      cur = $signed({1'b0, s.current_ma});
      r.load_enable = 1'b0;
      r.half_load_cmd = 1'b0;

      if (st == STOP_RUNNING) begin
        if (n != '1) n = n + 1'b1;
        if (high_curr >= 0 && cur >= high_curr) st = STOP_HIGH_CURR;
        // trapezoid step only once the idle samples are behind
        if ((n - 1'b1) > idle) begin
          isum = 64'(s.current_ma) + 64'(pi);
          vsum = 64'(s.voltage_mv) + 64'(pv);
          dt   = 64'(s.elapsed_ms);
          c = sat_add(c, isum * dt);
          e = sat_add(e, isum * vsum * dt);
        end
        pv = s.voltage_mv;
        pi = s.current_ma;
        if (st == STOP_RUNNING) begin
          // the half-load sample skips low-voltage counting
          if (half_volt != 0 && armed && s.voltage_mv <= half_volt) begin
            r.half_load_cmd = 1'b1;
            armed = 1'b0;
          end else begin
            if (confirm_step(vl, s.voltage_mv <= low_volt, nxt)) st = STOP_LOW_VOLT;
            vl = nxt;
          end
        end
        if (st == STOP_RUNNING && n > idle && low_curr >= 0) begin
          if (confirm_step(cl, cur <= low_curr, nxt)) st = STOP_LOW_CURR;
          cl = nxt;
        end
        if (st == STOP_RUNNING && n >= idle) r.load_enable = 1'b1;
      end

      r.sample_number = n;
      r.stop_reason   = st;
      r.charge_total  = c;
      r.energy_total  = e;
      if (commit) begin
        count = n; volt_left = vl; curr_left = cl; prev_v = pv; prev_i = pi;
        charge = c; energy = e; half_armed = armed; run_stop = st;
      end
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_q.push_back(advance(s, 1'b1));
    endfunction

    function stop_t stop_after(sample_t s);
      monitor_result_t r;
      r = advance(s, 1'b0);
      return r.stop_reason;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] at_sample,
                                logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s mismatch at sample %0d: expected %0d, got %0d",
                   name, at_sample, exp_val, act_val);
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] beat);
      monitor_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing expected, sample_number %0d", beat[CNT_W-1:0]);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("sample_number", exp_r.sample_number, exp_r.sample_number,
                    beat[CNT_W-1:0]);
      compare_field("stop_reason", exp_r.sample_number, exp_r.stop_reason,
                    beat[CNT_W+1:CNT_W]);
      compare_field("load_enable", exp_r.sample_number, exp_r.load_enable, beat[CNT_W+2]);
      compare_field("half_load_cmd", exp_r.sample_number, exp_r.half_load_cmd, beat[CNT_W+3]);
      compare_field("charge_total", exp_r.sample_number, exp_r.charge_total,
                    beat[CNT_W+4 +: OUT_ACC_W]);
      compare_field("energy_total", exp_r.sample_number, exp_r.energy_total,
                    beat[CNT_W+4+OUT_ACC_W +: OUT_ACC_W]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  discharge_scoreboard sb = new();

  // idle percentages, changed per phase by the main sequence
  int send_idle_pct;
  int recv_stall_pct;

  battery_discharge_monitor_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random back-pressure, changed only at the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result side monitor: every accepted result beat goes to the scoreboard
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // watchdog: ends the run once nothing has moved on either stream for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck = 0;
      else stuck++;
    end
    $display("[battery_discharge_monitor_top] ERROR");
    $finish;
  end

  function int clamp(int x, int hi);
    if (x < 0) return 0;
    if (x > hi) return hi;
    return x;
  endfunction

  // value within spread of a level, the region where the thresholds decide
  function int near(int base, int spread, int hi);
    int r;
    r = $urandom_range(0, 2 * spread);
    return clamp(base + r - spread, hi);
  endfunction

  // mostly samples around the configured levels or the last sample, some full range
  function sample_t next_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0, 1:    s.voltage_mv = $urandom_range(0, VOLT_MAX);
      2:       s.voltage_mv = near(int'(sb.half_volt), 100, VOLT_MAX);
      3, 4:    s.voltage_mv = near(int'(sb.prev_v), 40, VOLT_MAX);
      default: s.voltage_mv = near(int'(sb.low_volt), 100, VOLT_MAX);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: s.current_ma = $urandom_range(0, CURR_MAX);
      3, 4, 5: s.current_ma = near(int'(sb.low_curr), 50, CURR_MAX);
      6, 7:    s.current_ma = near(int'(sb.high_curr), 50, CURR_MAX);
      default: s.current_ma = near(int'(sb.prev_i), 20, CURR_MAX);
    endcase
    case ($urandom_range(0, 9))
      6, 7:    s.elapsed_ms = $urandom_range(0, TIME_MAX);
      8:       s.elapsed_ms = '0;
      9:       s.elapsed_ms = TIME_MAX;
      default: s.elapsed_ms = $urandom_range(0, 400);
    endcase
    return s;
  endfunction

  // the block only stops once per run, so stopping samples are steered away
  function sample_t keep_running(sample_t s);
    stop_t code;
    int    tries, lo, hi;
    for (tries = 0; tries < 4; tries++) begin
      code = sb.stop_after(s);
      if (sb.run_stop != STOP_RUNNING || code == STOP_RUNNING) break;
      if (code == STOP_LOW_VOLT) begin
        if (int'(sb.low_volt) < VOLT_MAX)
          s.voltage_mv = $urandom_range(int'(sb.low_volt) + 1, VOLT_MAX);
      end else begin
        lo = (sb.low_curr >= 0) ? int'(sb.low_curr) + 1 : 0;
        hi = (sb.high_curr >= 0) ? int'(sb.high_curr) - 1 : CURR_MAX;
        if (hi > CURR_MAX) hi = CURR_MAX;
        if (lo <= hi) s.current_ma = $urandom_range(lo, hi);
      end
    end
    return s;
  endfunction

  // one input beat; entered and left at a falling edge
  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({s.elapsed_ms, s.current_ma, s.voltage_mv});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic send_directed(input int v, input int i, input int dt);
    sample_t s;
    s.voltage_mv = v;
    s.current_ma = i;
    s.elapsed_ms = dt;
    send_sample(keep_running(s));
  endtask

  // sender holds off until every owed result beat has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.configure(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // current levels are signed, -1 disables them
  task automatic set_config(input int lv, input int hv, input int lc, input int hc,
                            input int conf, input int idle_n);
    cfg_write(CFG_LOW_VOLT,  CFG_DATA_W'(lv));
    cfg_write(CFG_HALF_VOLT, CFG_DATA_W'(hv));
    cfg_write(CFG_LOW_CURR,  CFG_DATA_W'(lc & 32'h1FFFF));
    cfg_write(CFG_HIGH_CURR, CFG_DATA_W'(hc & 32'h1FFFF));
    cfg_write(CFG_CONFIRM,   CFG_DATA_W'(conf));
    cfg_write(CFG_IDLE,      CFG_DATA_W'(idle_n));
  endtask

  // random levels kept so that high current lies above low current
  task automatic random_config();
    int lv, hv, lc, hc, conf, idle_n;
    lv = $urandom_range(0, 120000);
    hv = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 150000);
    lc = ($urandom_range(0, 9) < 3) ? -1 : $urandom_range(0, 20000);
    hc = ($urandom_range(0, 9) < 3) ? -1 : $urandom_range(((lc < 0) ? 0 : lc) + 2, CURR_MAX);
    conf = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 255);
    idle_n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(0, 300);
    set_config(lv, hv, lc, hc, conf, idle_n);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
      3:       begin send_idle_pct = 19; recv_stall_pct = 19; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic run_phase(input int n_items, input bit steer);
    sample_t s;
    int      k;
    for (k = 0; k < n_items; k++) begin
      // occasional full drain so the block runs dry between beats
      if (k == n_items / 2 || $urandom_range(0, 99) < 2) drain_results();
      s = next_sample();
      if (steer) s = keep_running(s);
      send_sample(s);
    end
  endtask

  initial begin
    int ph;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // power-up levels: low 100 mV, confirm 3, idle 3, current checks off
    set_idling(0);
    send_directed(0, 0, 0);
    send_directed(VOLT_MAX, CURR_MAX, TIME_MAX);
    send_directed(100, 1, 1);                  // exactly on the low level
    send_directed(101, CURR_MAX, 0);
    send_directed(VOLT_MAX, CURR_MAX, TIME_MAX); // first integrated sample
    send_directed(0, 0, TIME_MAX);
    send_directed(0, 0, 1);
    send_directed(5000, 1234, 250);

    drain_results();
    set_config(1000, 3000, 200, 60000, 4, 0);
    cfg_write(CFG_UNMAPPED_A, '1);
    cfg_write(CFG_UNMAPPED_B, '1);
    send_directed(4000, 500, 100);
    send_directed(3000, 500, 100);             // half level reached, single half-load
    send_directed(2500, 500, 100);
    send_directed(3000, 500, 100);             // disarmed, no second command
    send_directed(1000, 200, 100);             // both levels hit on the boundary
    send_directed(999, 199, 100);
    send_directed(1001, 201, 100);             // counters recover
    send_directed(0, 0, 0);
    send_directed(VOLT_MAX, 59999, TIME_MAX);  // just under high current
    send_directed(1500, 59999, 0);

    // random phases, each with its own levels and idling mix
    for (ph = 0; ph < 8; ph++) begin
      drain_results();
      set_idling(ph % 4);
      case (ph)
        1:       set_config(0, VOLT_MAX, CURR_MAX, -1, 255, IDLE_W'('1)); // wide extremes
        3:       set_config(50000, 0, -1, CURR_MAX, 1, 0);
        4:       set_config(2000, 1, 0, CURR_MAX, 0, 1);  // zero confirm count acts as one
        default: random_config();
      endcase
      run_phase(190, 1'b1);
    end

    // closing phase: let one stop happen, then check the held state
    drain_results();
    set_idling($urandom_range(0, 3));
    case ($urandom_range(0, 2))
      0:       set_config(VOLT_MAX, 0, -1, -1, $urandom_range(1, 4), 0);
      1:       set_config(0, 0, CURR_MAX, -1, $urandom_range(1, 4), 0);
      default: set_config(0, 0, -1, $urandom_range(0, 1000), 3, 0);
    endcase
    run_phase(40, 1'b0);
    drain_results();
    cfg_write(CFG_CONFIRM, CFG_DATA_W'($urandom_range(1, 255))); // reload must not restart
    run_phase(10, 1'b0);

    drain_results();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[battery_discharge_monitor_top] OK");
    end else begin
      $display("[battery_discharge_monitor_top] ERROR");
    end
    $finish;
  end

endmodule
